// ===== rtl/ucl_pkg.sv =====
// Package with the codes, register addresses and bit positions of the serial port register block.
`default_nettype none

package ucl_pkg;

    typedef enum logic [1:0] {
        FUNC_READ    = 2'd0,
        FUNC_WRITE   = 2'd1,
        FUNC_RX_CHAR = 2'd2,
        FUNC_TX_DONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ADDR_STATUS  = 2'd0,
        ADDR_DATA    = 2'd1,
        ADDR_DIVISOR = 2'd2,
        ADDR_CONTROL = 2'd3
    } addr_t;

    localparam int unsigned CB_RE     = 2;
    localparam int unsigned CB_TE     = 3;
    localparam int unsigned CB_RXNEIE = 5;
    localparam int unsigned CB_TCIE   = 6;
    localparam int unsigned CB_TXEIE  = 7;
    localparam int unsigned CB_PEIE   = 8;
    localparam int unsigned CB_PS     = 9;
    localparam int unsigned CB_PCE    = 10;
    localparam int unsigned CB_M      = 12;
    localparam int unsigned CB_UE     = 13;

    localparam int unsigned SR_PE   = 0;
    localparam int unsigned SR_ORE  = 3;
    localparam int unsigned SR_RXNE = 5;
    localparam int unsigned SR_TC   = 6;
    localparam int unsigned SR_TXE  = 7;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 32;

endpackage

`default_nettype wire

// ===== rtl/uart_char_level_registers.sv =====
// Top level of the character-level serial port register block.
`default_nettype none

// Each slave transfer carries one bus access or line event; tuser holds the function code.
// One transfer is accepted per clock unless m_tready holds the output back; an item goes
// through an input register and then the output register, which drives the master transfer.
// All state updates for an item happen in the single cycle in which it moves from the input
// register to the output register.
module uart_char_level_registers
    import ucl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // Fields from bit 0: reg_addr[1:0], write_data[17:2], rx_frame[26:18], zero fill.
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: func[1:0].
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // Fields from bit 0: read_data[15:0], tx_valid[16], tx_frame[25:17], irq[26], zero fill.
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic        in_valid_reg;
    func_t       in_func_reg;
    addr_t       in_addr_reg;
    logic [15:0] in_wdata_reg;
    logic [8:0]  in_frame_reg;

    logic        out_valid_reg;
    logic [15:0] out_rdata_reg;
    logic        out_txv_reg;
    logic [8:0]  out_txf_reg;
    logic        out_irq_reg;

    logic [15:0] ctrl_reg, ctrl_next;
    logic [15:0] div_reg, div_next;
    logic [8:0]  hold_reg, hold_next;
    logic        hold_full_reg, hold_full_next;
    logic        busy_reg, busy_next;
    logic        tc_reg, tc_next;
    logic [8:0]  rxd_reg, rxd_next;
    logic        rxne_reg, rxne_next;
    logic        pe_reg, pe_next;
    logic        ore_reg, ore_next;

    logic [15:0] rdata;
    logic        txv;
    logic [8:0]  txf;
    logic        irq;
    logic [8:0]  rx_word;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_irq_reg, out_txf_reg, out_txv_reg, out_rdata_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg  <= func_t'(s_tuser);
            in_addr_reg  <= addr_t'(s_tdata[1:0]);
            in_wdata_reg <= s_tdata[17:2];
            in_frame_reg <= s_tdata[26:18];
        end
        if (advance)
        begin
            out_rdata_reg <= rdata;
            out_txv_reg   <= txv;
            out_txf_reg   <= txf;
            out_irq_reg   <= irq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= 16'd0;
            div_reg       <= 16'd0;
            hold_reg      <= 9'd0;
            hold_full_reg <= 1'b0;
            busy_reg      <= 1'b0;
            tc_reg        <= 1'b1;
            rxd_reg       <= 9'd0;
            rxne_reg      <= 1'b0;
            pe_reg        <= 1'b0;
            ore_reg       <= 1'b0;
        end
        else if (advance)
        begin
            ctrl_reg      <= ctrl_next;
            div_reg       <= div_next;
            hold_reg      <= hold_next;
            hold_full_reg <= hold_full_next;
            busy_reg      <= busy_next;
            tc_reg        <= tc_next;
            rxd_reg       <= rxd_next;
            rxne_reg      <= rxne_next;
            pe_reg        <= pe_next;
            ore_reg       <= ore_next;
        end
    end

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        div_next       = div_reg;
        hold_next      = hold_reg;
        hold_full_next = hold_full_reg;
        busy_next      = busy_reg;
        tc_next        = tc_reg;
        rxd_next       = rxd_reg;
        rxne_next      = rxne_reg;
        pe_next        = pe_reg;
        ore_next       = ore_reg;
        rdata          = 16'd0;
        txv            = 1'b0;
        txf            = 9'd0;
        rx_word        = ctrl_reg[CB_M] ? in_frame_reg : {1'b0, in_frame_reg[7:0]};

        unique case (in_func_reg)
            FUNC_READ:
            begin
                unique case (in_addr_reg)
                    ADDR_STATUS:
                    begin
                        rdata[SR_PE]   = pe_reg;
                        rdata[SR_ORE]  = ore_reg;
                        rdata[SR_RXNE] = rxne_reg;
                        rdata[SR_TC]   = tc_reg;
                        rdata[SR_TXE]  = !hold_full_reg;
                    end
                    ADDR_DATA:
                    begin
                        rdata     = {7'd0, rxd_reg};
                        rxne_next = 1'b0;
                        pe_next   = 1'b0;
                        ore_next  = 1'b0;
                    end
                    ADDR_DIVISOR:
                    begin
                        rdata = div_reg;
                    end
                    ADDR_CONTROL:
                    begin
                        rdata = ctrl_reg;
                    end
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (in_addr_reg)
                    ADDR_STATUS:
                    begin
                        if (!in_wdata_reg[SR_RXNE])
                        begin
                            rxne_next = 1'b0;
                        end
                        if (!in_wdata_reg[SR_TC])
                        begin
                            tc_next = 1'b0;
                        end
                    end
                    ADDR_DATA:
                    begin
                        hold_next      = in_wdata_reg[8:0];
                        hold_full_next = 1'b1;
                        tc_next        = 1'b0;
                    end
                    ADDR_DIVISOR:
                    begin
                        div_next = in_wdata_reg;
                    end
                    ADDR_CONTROL:
                    begin
                        ctrl_next = in_wdata_reg;
                    end
                endcase
            end
            FUNC_RX_CHAR:
            begin
                if (ctrl_reg[CB_UE] && ctrl_reg[CB_RE])
                begin
                    if (rxne_reg)
                    begin
                        ore_next = 1'b1;
                    end
                    else
                    begin
                        rxd_next  = rx_word;
                        rxne_next = 1'b1;
                        if (ctrl_reg[CB_PCE] && ((^rx_word) != ctrl_reg[CB_PS]))
                        begin
                            pe_next = 1'b1;
                        end
                    end
                end
            end
            FUNC_TX_DONE:
            begin
                if (busy_reg)
                begin
                    busy_next = 1'b0;
                    if (!hold_full_reg)
                    begin
                        tc_next = 1'b1;
                    end
                end
            end
        endcase

        // The transmit start sees the state and control bits after this item's update.
        if (hold_full_next && !busy_next && ctrl_next[CB_UE] && ctrl_next[CB_TE])
        begin
            txv            = 1'b1;
            busy_next      = 1'b1;
            hold_full_next = 1'b0;
            if (ctrl_next[CB_M])
            begin
                txf = hold_next;
                if (ctrl_next[CB_PCE])
                begin
                    txf[8] = (^hold_next[7:0]) ^ ctrl_next[CB_PS];
                end
            end
            else
            begin
                txf = {1'b0, hold_next[7:0]};
                if (ctrl_next[CB_PCE])
                begin
                    txf[7] = (^hold_next[6:0]) ^ ctrl_next[CB_PS];
                end
            end
        end

        irq = (ctrl_next[CB_PEIE] && pe_next)
            || (ctrl_next[CB_TXEIE] && !hold_full_next)
            || (ctrl_next[CB_TCIE] && tc_next)
            || (ctrl_next[CB_RXNEIE] && (rxne_next || ore_next));
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the character-level serial port register block.
`timescale 1ns / 1ps

module tb;
    import ucl_pkg::*;

    localparam int N_RANDOM   = 1924;
    localparam int N_QUIET    = 300;
    localparam int LONG_HOLD  = 150;
    localparam int IDLE_LIMIT = 3000;

    typedef struct packed {
        func_t       func;
        addr_t       addr;
        logic [15:0] wdata;
        logic [8:0]  frame;
    } port_op_t;

    typedef struct packed {
        logic [15:0] rdata;
        logic        txv;
        logic [8:0]  txf;
        logic        irq;
    } port_res_t;

    typedef struct {
        port_op_t  op;
        bit        typed;
        port_res_t res;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [15:0] ctrl_reg = '0;
    logic [15:0] divisor_reg = '0;
    logic [8:0]  hold_word = '0;
    logic        hold_full = 1'b0;
    logic        tx_busy = 1'b0;
    logic        tc_flag = 1'b1;
    logic [8:0]  rx_word = '0;
    logic        rx_full = 1'b0;
    logic        pe_flag = 1'b0;
    logic        ore_flag = 1'b0;

    port_res_t pending_results[$];
    row_t      dir_rows[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        long_hold_req = 1'b0;
    bit        quiet = 1'b0;

    uart_char_level_registers uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic port_res_t next_port_result(input port_op_t op);
        port_res_t  r;
        logic       nine;
        logic [8:0] v;
        r = '0;
        case (op.func)
            FUNC_READ:
                case (op.addr)
                    ADDR_STATUS:
                    begin
                        r.rdata[SR_PE]   = pe_flag;
                        r.rdata[SR_ORE]  = ore_flag;
                        r.rdata[SR_RXNE] = rx_full;
                        r.rdata[SR_TC]   = tc_flag;
                        r.rdata[SR_TXE]  = ~hold_full;
                    end
                    ADDR_DATA:
                    begin
                        r.rdata  = {7'b0, rx_word};
                        rx_full  = 1'b0;
                        pe_flag  = 1'b0;
                        ore_flag = 1'b0;
                    end
                    ADDR_DIVISOR: r.rdata = divisor_reg;
                    default:      r.rdata = ctrl_reg;
                endcase
            FUNC_WRITE:
                case (op.addr)
                    ADDR_STATUS:
                    begin
                        if (!op.wdata[SR_RXNE])
                            rx_full = 1'b0;
                        if (!op.wdata[SR_TC])
                            tc_flag = 1'b0;
                    end
                    ADDR_DATA:
                    begin
                        hold_word = op.wdata[8:0];
                        hold_full = 1'b1;
                        tc_flag   = 1'b0;
                    end
                    ADDR_DIVISOR: divisor_reg = op.wdata;
                    default:      ctrl_reg = op.wdata;
                endcase
            FUNC_RX_CHAR:
                if (ctrl_reg[CB_UE] && ctrl_reg[CB_RE])
                begin
                    if (rx_full)
                        ore_flag = 1'b1;
                    else
                    begin
                        v = ctrl_reg[CB_M] ? op.frame : {1'b0, op.frame[7:0]};
                        rx_word = v;
                        rx_full = 1'b1;
                        if (ctrl_reg[CB_PCE] && ((^v) != ctrl_reg[CB_PS]))
                            pe_flag = 1'b1;
                    end
                end
            default:
                if (tx_busy)
                begin
                    tx_busy = 1'b0;
                    if (!hold_full)
                        tc_flag = 1'b1;
                end
        endcase

        if (hold_full && !tx_busy && ctrl_reg[CB_UE] && ctrl_reg[CB_TE])
        begin
            nine = ctrl_reg[CB_M];
            v = nine ? hold_word : {1'b0, hold_word[7:0]};
            if (ctrl_reg[CB_PCE])
            begin
                if (nine)
                    v[8] = (^v[7:0]) ^ ctrl_reg[CB_PS];
                else
                    v[7] = (^v[6:0]) ^ ctrl_reg[CB_PS];
            end
            r.txv     = 1'b1;
            r.txf     = v;
            tx_busy   = 1'b1;
            hold_full = 1'b0;
        end

        r.irq = (ctrl_reg[CB_PEIE] & pe_flag) | (ctrl_reg[CB_TXEIE] & ~hold_full)
              | (ctrl_reg[CB_TCIE] & tc_flag) | (ctrl_reg[CB_RXNEIE] & (rx_full | ore_flag));
        return r;
    endfunction

    function automatic port_op_t rand_port_op();
        port_op_t    op;
        int unsigned pick;
        op.wdata = 16'($urandom);
        op.frame = 9'($urandom);
        op.addr  = addr_t'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 28)
            op.func = FUNC_READ;
        else if (pick < 58)
        begin
            op.func = FUNC_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op.addr = ADDR_DATA;
            else if (pick < 60)
                op.addr = ADDR_STATUS;
            else if (pick < 75)
                op.addr = ADDR_DIVISOR;
            else
            begin
                op.addr = ADDR_CONTROL;
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    op.wdata = '0;
                else if (pick == 1)
                    op.wdata = '1;
                else if (pick < 14)
                begin
                    op.wdata[CB_UE] = 1'b1;
                    op.wdata[CB_RE] = 1'b1;
                    op.wdata[CB_TE] = 1'b1;
                end
            end
        end
        else if (pick < 80)
            op.func = FUNC_RX_CHAR;
        else
            op.func = FUNC_TX_DONE;
        return op;
    endfunction

    task automatic add_row(input func_t f, input addr_t a, input logic [15:0] wd,
                           input logic [8:0] fr, input bit typed,
                           input logic [15:0] rd, input logic irq);
        row_t rw;
        rw.op    = '{func: f, addr: a, wdata: wd, frame: fr};
        rw.typed = typed;
        rw.res   = '{rdata: rd, txv: 1'b0, txf: 9'h000, irq: irq};
        dir_rows.push_back(rw);
    endtask

    // Holds one item on the slave side until its transfer, then records what it should produce.
    task automatic offer(input port_op_t op, input bit allow_gap, input bit typed,
                         input port_res_t typed_res);
        int        gap;
        port_res_t predicted;
        gap = (allow_gap && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({op.frame, op.wdata, op.addr});
        s_tuser  <= op.func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = next_port_result(op);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int i;
        add_row(FUNC_READ,    ADDR_STATUS,  16'h0000, 9'h000, 1'b1, 16'h00C0, 1'b0);
        add_row(FUNC_READ,    ADDR_DATA,    16'h0000, 9'h000, 1'b1, 16'h0000, 1'b0);
        add_row(FUNC_READ,    ADDR_DIVISOR, 16'h0000, 9'h000, 1'b1, 16'h0000, 1'b0);
        add_row(FUNC_READ,    ADDR_CONTROL, 16'h0000, 9'h000, 1'b1, 16'h0000, 1'b0);
        add_row(FUNC_RX_CHAR, ADDR_STATUS,  16'h0000, 9'h1FF, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_DIVISOR, 16'hFFFF, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_READ,    ADDR_DIVISOR, 16'h0000, 9'h000, 1'b1, 16'hFFFF, 1'b0);
        add_row(FUNC_WRITE,   ADDR_CONTROL, 16'hFFFF, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_READ,    ADDR_CONTROL, 16'h0000, 9'h000, 1'b1, 16'hFFFF, 1'b1);
        add_row(FUNC_WRITE,   ADDR_DATA,    16'h01FF, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_DATA,    16'h00AA, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_DATA,    16'h0155, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_TX_DONE, ADDR_DATA,    16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_TX_DONE, ADDR_DATA,    16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_TX_DONE, ADDR_DATA,    16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_RX_CHAR, ADDR_DATA,    16'h0000, 9'h1FF, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_RX_CHAR, ADDR_DATA,    16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_READ,    ADDR_STATUS,  16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_READ,    ADDR_DATA,    16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_STATUS,  16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_CONTROL, 16'h2004, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_RX_CHAR, ADDR_DATA,    16'h0000, 9'h1FF, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_CONTROL, 16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_DATA,    16'hFFFF, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_WRITE,   ADDR_CONTROL, 16'h2608, 9'h000, 1'b0, 16'h0000, 1'b0);
        add_row(FUNC_READ,    ADDR_STATUS,  16'h0000, 9'h000, 1'b0, 16'h0000, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].op, 1'b1, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
                drain_results();
            if (i == N_RANDOM / 2)
                long_hold_req = 1'b1;
            if (i == N_RANDOM - N_QUIET)
                quiet = 1'b1;
            offer(rand_port_op(), !quiet, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : sink
        int n;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                n = 0;
                while (n < LONG_HOLD)
                begin
                    @(posedge clk);
                    n++;
                end
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        port_res_t got;
        port_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rdata = m_tdata[15:0];
            got.txv   = m_tdata[16];
            got.txf   = m_tdata[25:17];
            got.irq   = m_tdata[26];
            if (pending_results.size() == 0)
                report_mismatch("transfer with nothing expected, read_data", got.rdata, 16'h0);
            else
            begin
                want = pending_results.pop_front();
                if (got.rdata !== want.rdata)
                    report_mismatch("read_data", got.rdata, want.rdata);
                if (got.txv !== want.txv)
                    report_mismatch("tx_valid", 16'(got.txv), 16'(want.txv));
                if (got.txf !== want.txf)
                    report_mismatch("tx_frame", 16'(got.txf), 16'(want.txf));
                if (got.irq !== want.irq)
                    report_mismatch("irq", 16'(got.irq), 16'(want.irq));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
